@@ rtl/core/smf_pkg.sv @@
// Shared types, constants and arithmetic helpers of the sample filter block.
package smf_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 16;
	localparam int FRAC_W      = 16;
	localparam int WEIGHT_REGS = 5;
	localparam int TAPS_DEFAULT = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = COEF_W;

	// Wide working widths for products and accumulations
	localparam int PROD_W = 40;
	localparam int ACC_W  = 24;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_FIRST = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_LAST  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OLD_GAIN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_NEW_GAIN  = 3'd6;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [COEF_W-1:0] coef_t;

	localparam coef_t [WEIGHT_REGS-1:0] TAP_WEIGHT_RST =
		{16'd1861, 16'd15532, 16'd30749, 16'd15532, 16'd1861};
	localparam coef_t OLD_GAIN_RST = 16'd19661;
	localparam coef_t NEW_GAIN_RST = 16'd45875;

	typedef struct packed {
		coef_t [WEIGHT_REGS-1:0] tap_weight;
		coef_t                   old_gain;
		coef_t                   new_gain;
	} cfg_t;

	typedef struct packed {
		sample_t sample;
	} sample_item_t;

	typedef struct packed {
		sample_t raw_sample;
		sample_t moving_average;
		sample_t iir_output;
		sample_t fir_output;
	} result_item_t;

	// Pipeline advance controls shared between the stages
	typedef struct packed {
		logic take_s1;  // input transfer into stage 1
		logic load_s2;  // stage 2 registers may load
		logic item_s2;  // a real item moves from stage 1 into stage 2
		logic load_s3;  // output register may load
	} stage_en_t;

	localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'(2 ** FRAC_W - 1);
	localparam logic signed [ACC_W-1:0]  SAT_HI     = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [ACC_W-1:0]  SAT_LO     = -ACC_W'(2 ** (SAMPLE_W - 1));

	// Q0.16 product back to integer, truncating toward zero
	function automatic logic signed [ACC_W-1:0] trunc_q16(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] b;
		b = v + (v[PROD_W-1] ? TRUNC_BIAS : '0);
		return b[FRAC_W +: ACC_W];
	endfunction

	// Clamp to the signed sample range
	function automatic sample_t sat_sample(input logic signed [ACC_W-1:0] v);
		sample_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[SAMPLE_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SAMPLE_W-1:0];
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/smf_stream_if.sv @@
// Valid/ready stream channel carrying one payload item per transfer.
interface smf_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/sample_maf_fir_iir_filter.sv @@
// A transferred sample passes the stage 1, stage 2 and output registers to results.
// Throughput: one sample per cycle unless results stalls; IIR feedback is in stage 2.
// Stages: input register with history line, tap products and IIR, output register.
// Each stage fills while a later one is stalled, so bubbles are absorbed.
// Reset (arst_n, asynchronous, active low) clears history, IIR state and valids, and
// reloads the power-on weights and gains.
module sample_maf_fir_iir_filter #(
	parameter int TAPS = smf_pkg::TAPS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	smf_stream_if.sink                     samples,
	smf_stream_if.source                   results,
	input  logic                           cfg_write,
	input  logic [smf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import smf_pkg::*;

	// Moving average: exact divide by TAPS through a reciprocal multiply.
	// With N-bit magnitude and L = clog2(TAPS), floor(x*M / 2^(N+L)) equals x/TAPS
	// for every x below 2^N when M = floor(2^(N+L)/TAPS) + 1.
	localparam int SUM_W     = SAMPLE_W + $clog2(TAPS);
	localparam int AVG_SHIFT = SUM_W + $clog2(TAPS);
	localparam logic [SUM_W:0] AVG_MUL = (SUM_W + 1)'((2 ** AVG_SHIFT) / TAPS + 1);
	localparam int AVG_PROD_W = 2 * SUM_W + 1;

	// Handshake and stage control
	logic      v_s1, v_s2, v_s3;
	logic      rdy_s1, rdy_s2, rdy_s3;
	stage_en_t en;

	// Datapath signals
	cfg_t                    cfg;
	sample_t                 sample_s1;
	sample_t                 raw_s2;
	sample_t [TAPS-1:0]      taps;
	logic signed [SUM_W-1:0] ring_sum;
	logic [SUM_W-1:0]        avg_mag_s2;
	logic                    avg_neg_s2;
	logic [AVG_PROD_W-1:0]   avg_prod;
	logic [SAMPLE_W:0]       avg_q;
	logic [SAMPLE_W:0]       avg_val;
	sample_t                 fir_value;
	sample_t                 iir_value;
	result_item_t            res_s3;

	// A stage may load when it is empty or its content moves on this cycle
	assign rdy_s3 = !v_s3 || results.ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign en.take_s1 = samples.valid && rdy_s1;
	assign en.load_s2 = rdy_s2;
	assign en.item_s2 = v_s1 && rdy_s2;
	assign en.load_s3 = rdy_s3;

	assign samples.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= samples.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	smf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1: the history line shifts on each input transfer and so always
	// describes the item held in stage 1.
	smf_history #(.TAPS(TAPS)) u_history (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.sample   (samples.payload.sample),
		.taps     (taps),
		.ring_sum (ring_sum)
	);

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			sample_s1 <= samples.payload.sample;
		end
	end

	// Stage 2: tap products, IIR update, moving-average magnitude and sign
	smf_fir #(.TAPS(TAPS)) u_fir (
		.clk       (clk),
		.en        (en),
		.taps      (taps),
		.cfg       (cfg),
		.fir_value (fir_value)
	);

	smf_iir u_iir (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.sample    (sample_s1),
		.cfg       (cfg),
		.iir_value (iir_value)
	);

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			raw_s2     <= sample_s1;
			avg_neg_s2 <= ring_sum[SUM_W-1];
			avg_mag_s2 <= ring_sum[SUM_W-1] ? SUM_W'(-ring_sum) : SUM_W'(ring_sum);
		end
	end

	// Divide the magnitude, then restore the sign: truncation toward zero
	always_comb begin
		avg_prod = AVG_PROD_W'(avg_mag_s2) * AVG_PROD_W'(AVG_MUL);
		avg_q    = avg_prod[AVG_SHIFT +: SAMPLE_W + 1];
		avg_val  = avg_neg_s2 ? -avg_q : avg_q;
	end

	// Stage 3: output register; hold while the sink stalls
	always_ff @(posedge clk) begin
		if (en.load_s3) begin
			res_s3.raw_sample     <= raw_s2;
			res_s3.moving_average <= avg_val[SAMPLE_W-1:0];
			res_s3.iir_output     <= iir_value;
			res_s3.fir_output     <= fir_value;
		end
	end

	assign results.valid   = v_s3;
	assign results.payload = res_s3;

	// A stalled stage 1 must block the input
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy_s2) |-> !samples.ready)
		else $error("input accepted while stage 1 is stalled");

	// An item leaving stage 2 must show up as a result
	a_s2_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && rdy_s3) |=> results.valid)
		else $error("item lost between stage 2 and the output register");

	// The quotient never exceeds the sample magnitude range
	a_avg_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (!avg_q[SAMPLE_W] || avg_q[SAMPLE_W-1:0] == '0))
		else $error("moving average quotient out of range");

	// IIR state changes only when an item enters stage 2
	a_iir_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en.item_s2 |=> $stable(iir_value))
		else $error("IIR state changed without an item");

endmodule

@@ rtl/core/smf_cfg_regs.sv @@
// Configuration register file: FIR tap weights and IIR gains.
module smf_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [smf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smf_pkg::CFG_DATA_W-1:0] cfg_data,
	output smf_pkg::cfg_t                  cfg
);
	import smf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_weight <= TAP_WEIGHT_RST;
			cfg_q.old_gain   <= OLD_GAIN_RST;
			cfg_q.new_gain   <= NEW_GAIN_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_OLD_GAIN: cfg_q.old_gain <= cfg_data;
				CFG_NEW_GAIN: cfg_q.new_gain <= cfg_data;
				default: begin
					// drop writes beyond the register list
					if (cfg_index inside {[CFG_TAP_FIRST:CFG_TAP_LAST]}) begin
						cfg_q.tap_weight[cfg_index] <= cfg_data;
					end
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/smf_history.sv @@
// Sample history shift line, newest first, with a running sum of its entries.
module smf_history #(
	parameter int TAPS = smf_pkg::TAPS_DEFAULT,
	localparam int SUM_W = smf_pkg::SAMPLE_W + $clog2(TAPS)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  smf_pkg::stage_en_t              en,
	input  smf_pkg::sample_t                sample,
	output smf_pkg::sample_t [TAPS-1:0]     taps,
	output logic signed [SUM_W-1:0]         ring_sum
);
	import smf_pkg::*;

	sample_t [TAPS-1:0]      taps_q;
	logic signed [SUM_W-1:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= '0;
			sum_q  <= '0;
		end else if (en.take_s1) begin
			taps_q[0] <= sample;
			for (int i = 1; i < TAPS; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
			// add the newcomer, drop the oldest entry
			sum_q <= sum_q + SUM_W'(sample) - SUM_W'(taps_q[TAPS-1]);
		end
	end

	assign taps     = taps_q;
	assign ring_sum = sum_q;

endmodule

@@ rtl/core/smf_fir.sv @@
// FIR datapath: registered tap products, then truncating sum and saturation.
module smf_fir #(
	parameter int TAPS = smf_pkg::TAPS_DEFAULT
) (
	input  logic                        clk,
	input  smf_pkg::stage_en_t          en,
	input  smf_pkg::sample_t [TAPS-1:0] taps,
	input  smf_pkg::cfg_t               cfg,
	output smf_pkg::sample_t            fir_value
);
	import smf_pkg::*;

	localparam int FIR_TAPS = (TAPS < WEIGHT_REGS) ? TAPS : WEIGHT_REGS;
	localparam int MUL_W    = SAMPLE_W + COEF_W + 1;

	logic signed [MUL_W-1:0] prod_s2 [FIR_TAPS];
	logic signed [ACC_W-1:0] acc;

	always_ff @(posedge clk) begin
		if (en.load_s2) begin
			for (int a = 0; a < FIR_TAPS; a++) begin
				prod_s2[a] <= $signed(taps[a]) * $signed({1'b0, cfg.tap_weight[a]});
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int a = 0; a < FIR_TAPS; a++) begin
			acc = acc + trunc_q16(PROD_W'(prod_s2[a]));
		end
		fir_value = sat_sample(acc);
	end

endmodule

@@ rtl/core/smf_iir.sv @@
// First-order recursive filter holding the previous output.
module smf_iir (
	input  logic               clk,
	input  logic               arst_n,
	input  smf_pkg::stage_en_t en,
	input  smf_pkg::sample_t   sample,
	input  smf_pkg::cfg_t      cfg,
	output smf_pkg::sample_t   iir_value
);
	import smf_pkg::*;

	localparam int TERM_W = SAMPLE_W + COEF_W + 2;

	sample_t                  prev_iir_q;
	logic signed [TERM_W-1:0] old_term;
	logic signed [TERM_W-1:0] new_term;
	logic signed [TERM_W-1:0] mix;
	sample_t                  iir_next;

	always_comb begin
		old_term = $signed({1'b0, cfg.old_gain}) * prev_iir_q;
		new_term = $signed({1'b0, cfg.new_gain}) * sample;
		mix      = old_term + new_term;
		iir_next = sat_sample(trunc_q16(PROD_W'(mix)));
	end

	// advance only when a real item enters stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_iir_q <= '0;
		end else if (en.item_s2) begin
			prev_iir_q <= iir_next;
		end
	end

	assign iir_value = prev_iir_q;

endmodule

@@ test/sample_maf_fir_iir_filter_tb.sv @@
// Self-checking testbench of the sample filter: a directed script, then randomised phases.
module sample_maf_fir_iir_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smf_pkg::*;

	typedef logic [CFG_IDX_W-1:0] reg_index_t;

	// Ring depth of the instance; the predictor follows the same figure
	localparam int RING_DEPTH = TAPS_DEFAULT;
	localparam longint FRAC_ONE = longint'(1) << FRAC_W;
	localparam longint OUT_HI = 32767;
	localparam longint OUT_LO = -32768;
	localparam sample_t SAMPLE_MAX = 16'sh7FFF;
	localparam sample_t SAMPLE_MIN = 16'sh8000;
	localparam coef_t COEF_MAX = 16'hFFFF;
	localparam coef_t COEF_ZERO = 16'h0000;

	// Index past the last register: the block must drop writes to it
	localparam reg_index_t CFG_SPARE = 3'd7;

	localparam int IDLE_PCT = 24;       // chance in a hundred that a side idles in a cycle
	localparam int HOLD_CYCLES = 80;    // long receiver hold-off that backs the pipeline up
	localparam int DRAIN_CYCLES = 6;    // margin on top of the pipeline latency
	localparam int RANDOM_ITEMS = 1525;

	// Script rows with this index carry a sample; any other index is a register write
	localparam int SAMPLE_ROW = -1;

	typedef struct {
		int index;
		int value;
		bit typed;
		int raw;
		int avg;
		int iir;
		int fir;
	} script_row_t;

	localparam int SCRIPT_LEN = 46;

	// Directed script. Typed expectations only where the sums are trivial: the first
	// transfers after reset with the ring still filling, and an all-zero setting.
	script_row_t script [SCRIPT_LEN] = '{
		'{SAMPLE_ROW, 0, 1, 0, 0, 0, 0},
		'{SAMPLE_ROW, 5, 1, 5, 1, 3, 0},
		'{SAMPLE_ROW, -5, 1, -5, 0, -2, 1},
		'{SAMPLE_ROW, 32767, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, 32767, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, 32767, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, 32767, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, -32768, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, -32768, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, -32768, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, -32768, 0, 0, 0, 0, 0},
		// full-scale weights and gains: both filters must clip at either rail
		'{CFG_TAP_FIRST, 65535, 0, 0, 0, 0, 0},
		'{CFG_TAP_FIRST + 1, 65535, 0, 0, 0, 0, 0},
		'{CFG_TAP_FIRST + 2, 65535, 0, 0, 0, 0, 0},
		'{CFG_TAP_FIRST + 3, 65535, 0, 0, 0, 0, 0},
		'{CFG_TAP_LAST, 65535, 0, 0, 0, 0, 0},
		'{CFG_OLD_GAIN, 65535, 0, 0, 0, 0, 0},
		'{CFG_NEW_GAIN, 65535, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, 32767, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, 32767, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, 32767, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, 32767, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, 32767, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, -32768, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, -32768, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, -32768, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, -32768, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, -32768, 0, 0, 0, 0, 0},
		// everything to zero, then an out-of-range write that must not land anywhere
		'{CFG_TAP_FIRST, 0, 0, 0, 0, 0, 0},
		'{CFG_TAP_FIRST + 1, 0, 0, 0, 0, 0, 0},
		'{CFG_TAP_FIRST + 2, 0, 0, 0, 0, 0, 0},
		'{CFG_TAP_FIRST + 3, 0, 0, 0, 0, 0, 0},
		'{CFG_TAP_LAST, 0, 0, 0, 0, 0, 0},
		'{CFG_OLD_GAIN, 0, 0, 0, 0, 0, 0},
		'{CFG_NEW_GAIN, 0, 0, 0, 0, 0, 0},
		'{CFG_SPARE, 65535, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, 12345, 1, 12345, -23745, 0, 0},
		// back to the power-on values
		'{CFG_TAP_FIRST, 1861, 0, 0, 0, 0, 0},
		'{CFG_TAP_FIRST + 1, 15532, 0, 0, 0, 0, 0},
		'{CFG_TAP_FIRST + 2, 30749, 0, 0, 0, 0, 0},
		'{CFG_TAP_FIRST + 3, 15532, 0, 0, 0, 0, 0},
		'{CFG_TAP_LAST, 1861, 0, 0, 0, 0, 0},
		'{CFG_OLD_GAIN, 19661, 0, 0, 0, 0, 0},
		'{CFG_NEW_GAIN, 45875, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, 21845, 0, 0, 0, 0, 0},
		'{SAMPLE_ROW, -21846, 0, 0, 0, 0, 0}
	};

	logic clk;
	logic arst_n;
	logic cfg_write;
	reg_index_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	smf_stream_if #(.T(sample_item_t)) samples_ch ();
	smf_stream_if #(.T(result_item_t)) results_ch ();

	sample_maf_fir_iir_filter #(
		.TAPS(RING_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_ch),
		.results(results_ch),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state: sample history, IIR memory and a mirror of the registers
	sample_t history [RING_DEPTH];
	int slot_next;
	sample_t iir_memory;
	cfg_t gains;

	// Results owed by the block, oldest first
	result_item_t awaited [$];
	int mismatches = 0;

	// Idling controls shared with the receiver
	bit calm = 0;
	int squeeze_asked = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run
	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	function automatic sample_t clip16(longint v);
		if (v > OUT_HI) begin
			return SAMPLE_MAX;
		end
		if (v < OUT_LO) begin
			return SAMPLE_MIN;
		end
		return sample_t'(v);
	endfunction

	// Advance the predictor by one sample and return the result it owes
	function automatic result_item_t filter_step(sample_t s);
		longint ring_sum;
		longint fir_acc;
		longint iir_acc;
		longint entry;
		longint weight;
		int age;
		int slot;
		result_item_t r;
		history[slot_next] = s;
		ring_sum = 0;
		fir_acc = 0;
		// walk by age: age zero is the sample just written
		for (age = 0; age < RING_DEPTH; age++) begin
			slot = (slot_next + RING_DEPTH - age) % RING_DEPTH;
			entry = history[slot];
			weight = (age < WEIGHT_REGS) ? longint'(gains.tap_weight[age]) : 0;
			ring_sum += entry;
			// each product truncated toward zero on its own before the sum
			fir_acc += (entry * weight) / FRAC_ONE;
		end
		iir_acc = (longint'(gains.old_gain) * longint'(iir_memory)
			+ longint'(gains.new_gain) * longint'(s)) / FRAC_ONE;
		iir_memory = clip16(iir_acc);
		r.raw_sample = s;
		r.moving_average = sample_t'(ring_sum / RING_DEPTH);
		r.iir_output = iir_memory;
		r.fir_output = clip16(fir_acc);
		slot_next = (slot_next + 1) % RING_DEPTH;
		return r;
	endfunction

	function automatic void check_field(string name, sample_t want, sample_t got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Offer one sample, idling at random first; log the expectation on transfer
	task automatic offer(sample_t s, bit typed, result_item_t typed_res);
		result_item_t predicted;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			samples_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.payload <= '{sample: s};
		do begin
			@(posedge clk);
		end while (!samples_ch.ready);
		// the predictor must advance even when the expectation is typed in
		predicted = filter_step(s);
		awaited.push_back(typed ? typed_res : predicted);
	endtask

	// Drop valid and hold until every owed result has come out
	task automatic settle();
		samples_ch.valid <= 1'b0;
		while (awaited.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; the caller lowers the enable once its run of writes is done
	task automatic write_reg(reg_index_t idx, coef_t val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == CFG_OLD_GAIN) begin
			gains.old_gain = val;
		end else if (idx == CFG_NEW_GAIN) begin
			gains.new_gain = val;
		end else if (idx <= CFG_TAP_LAST) begin
			gains.tap_weight[idx - CFG_TAP_FIRST] = val;
		end
	endtask

	// Receiver: check each transfer, then pick the next ready
	initial begin
		int hold_left;
		int squeeze_served;
		bit take;
		result_item_t want;
		hold_left = 0;
		squeeze_served = 0;
		results_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (results_ch.valid && results_ch.ready) begin
				if (awaited.size() == 0) begin
					mismatches++;
					$display("%0t result with nothing owed: expected none, actual %p",
						$time, results_ch.payload);
				end else begin
					want = awaited.pop_front();
					check_field("raw_sample", want.raw_sample,
						results_ch.payload.raw_sample);
					check_field("moving_average", want.moving_average,
						results_ch.payload.moving_average);
					check_field("iir_output", want.iir_output,
						results_ch.payload.iir_output);
					check_field("fir_output", want.fir_output,
						results_ch.payload.fir_output);
				end
			end
			// a hold-off counts its own cycles, whatever the sender is doing
			if (squeeze_served < squeeze_asked) begin
				squeeze_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else begin
				take = calm || ($urandom_range(99) >= IDLE_PCT);
			end
			results_ch.ready <= take;
		end
	end

	// Stimulus: reset, directed script, randomised phases, drain
	initial begin
		script_row_t row;
		result_item_t typed_res;
		cfg_t plan;
		sample_t s;
		bit writing;
		int sent;
		int span;
		int j;
		int t;
		int phase;

		// drive every input to a known level from time zero
		arst_n <= 1'b0;
		samples_ch.valid <= 1'b0;
		samples_ch.payload <= '0;
		cfg_write <= 1'b0;
		cfg_index <= CFG_TAP_FIRST;
		cfg_data <= '0;

		// mirror the power-on state
		foreach (history[k]) begin
			history[k] = '0;
		end
		slot_next = 0;
		iir_memory = '0;
		gains.tap_weight = TAP_WEIGHT_RST;
		gains.old_gain = OLD_GAIN_RST;
		gains.new_gain = NEW_GAIN_RST;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the script. Registers change only with the pipeline empty, so settle
		// before the first write of each run and lower the enable before samples resume.
		writing = 0;
		foreach (script[i]) begin
			row = script[i];
			if (row.index == SAMPLE_ROW) begin
				if (writing) begin
					cfg_write <= 1'b0;
					writing = 0;
				end
				typed_res.raw_sample = sample_t'(row.raw);
				typed_res.moving_average = sample_t'(row.avg);
				typed_res.iir_output = sample_t'(row.iir);
				typed_res.fir_output = sample_t'(row.fir);
				offer(sample_t'(row.value), row.typed, typed_res);
			end else begin
				if (!writing) begin
					settle();
				end
				write_reg(reg_index_t'(row.index), coef_t'(row.value));
				writing = 1;
			end
		end

		// Random phases: settle, load a fresh setting, then a burst of samples
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(5))
				0: begin
					plan.tap_weight = TAP_WEIGHT_RST;
					plan.old_gain = OLD_GAIN_RST;
					plan.new_gain = NEW_GAIN_RST;
				end
				1: plan = '0;
				2: plan = '1;
				3: begin
					// modest weights keep the FIR mostly off the rails
					for (t = 0; t < WEIGHT_REGS; t++) begin
						plan.tap_weight[t] = coef_t'($urandom_range(16383));
					end
					plan.old_gain = coef_t'($urandom_range(32767));
					plan.new_gain = coef_t'($urandom_range(32767));
				end
				default: begin
					plan = '0;
					for (t = 0; t < WEIGHT_REGS; t++) begin
						plan.tap_weight[t] = ($urandom_range(3) == 0)
							? (($urandom_range(1) == 0) ? COEF_ZERO : COEF_MAX)
							: coef_t'($urandom);
					end
					plan.old_gain = coef_t'($urandom);
					plan.new_gain = coef_t'($urandom);
				end
			endcase
			for (t = 0; t < WEIGHT_REGS; t++) begin
				write_reg(reg_index_t'(CFG_TAP_FIRST + t), plan.tap_weight[t]);
			end
			write_reg(CFG_OLD_GAIN, plan.old_gain);
			write_reg(CFG_NEW_GAIN, plan.new_gain);
			if ($urandom_range(3) == 0) begin
				write_reg(CFG_SPARE, coef_t'($urandom));
			end
			cfg_write <= 1'b0;

			// one phase with no idling at all; a later one backs the pipeline up
			calm = (phase == 2) || (phase == 4);
			if (phase == 4) begin
				squeeze_asked++;
			end

			span = $urandom_range(160, 40);
			for (j = 0; j < span && sent < RANDOM_ITEMS; j++) begin
				case ($urandom_range(9))
					0: begin
						case ($urandom_range(3))
							0: s = SAMPLE_MAX;
							1: s = SAMPLE_MIN;
							2: s = '0;
							default: s = '1;
						endcase
					end
					1: s = sample_t'(int'($urandom_range(200)) - 100);
					default: s = sample_t'($urandom);
				endcase
				offer(s, 1'b0, '0);
				sent++;
			end
			phase++;
		end

		// Drain, then give any stray result time to show up
		calm = 0;
		settle();
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/smf_pkg.sv
rtl/core/smf_stream_if.sv
rtl/core/smf_cfg_regs.sv
rtl/core/smf_history.sv
rtl/core/smf_fir.sv
rtl/core/smf_iir.sv
rtl/core/sample_maf_fir_iir_filter.sv
test/sample_maf_fir_iir_filter_tb.sv
